### rtl/image_diff_error_statistics_core_macros.svh
// Assertion macros used by the back stage of the image difference statistics RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef IMAGE_DIFF_ERROR_STATISTICS_CORE_MACROS_SVH
`define IMAGE_DIFF_ERROR_STATISTICS_CORE_MACROS_SVH

// Same-cycle implication.
`define IDS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define IDS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/idestat_pkg.sv
// Shared types, constants and functions for the image difference statistics core.
// No dependencies.
`timescale 1ns / 1ps

package idestat_pkg;

  localparam int unsigned MAX_PIXELS = 16777216;

  localparam int NUM_CH  = 4;
  localparam int CH_W    = 8;
  localparam int COUNT_W = 25;
  localparam int SUM_W   = 32;
  localparam int TOTAL_W = 34;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int CH_ALPHA = 3;

  localparam logic [COUNT_W-1:0] COUNT_FIELD_MAX = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_CAP =
    (64'(MAX_PIXELS) < 64'(COUNT_FIELD_MAX)) ? COUNT_W'(MAX_PIXELS) : COUNT_FIELD_MAX;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic [CH_W-1:0] own_red;
    logic [CH_W-1:0] own_green;
    logic [CH_W-1:0] own_blue;
    logic [CH_W-1:0] own_alpha;
    logic [CH_W-1:0] ref_red;
    logic [CH_W-1:0] ref_green;
    logic [CH_W-1:0] ref_blue;
    logic [CH_W-1:0] ref_alpha;
    logic            last_pixel;
  } pixel_t;

  typedef struct packed {
    logic               images_identical;
    logic [COUNT_W-1:0] mismatch_count;
    logic [SUM_W-1:0]   sum_red;
    logic [SUM_W-1:0]   sum_green;
    logic [SUM_W-1:0]   sum_blue;
    logic [SUM_W-1:0]   sum_alpha;
    logic [TOTAL_W-1:0] sum_all;
    logic [CH_W-1:0]    peak_red;
    logic [CH_W-1:0]    peak_green;
    logic [CH_W-1:0]    peak_blue;
    logic [CH_W-1:0]    peak_alpha;
    logic [CH_W-1:0]    peak_all;
  } result_t;

  typedef struct packed {
    logic [NUM_CH-1:0][CH_W-1:0] err;
    logic                        differs;
    logic                        last;
  } cls_t;

  typedef struct packed {
    logic [COUNT_W-1:0]           count;
    logic [NUM_CH-1:0][SUM_W-1:0] sums;
    logic [NUM_CH-1:0][CH_W-1:0]  peaks;
  } stat_t;

  function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [CH_W-1:0] max8(input logic [CH_W-1:0] a,
                                           input logic [CH_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

### rtl/idestat_front.sv
// Front stage: turns a pixel pair into per-channel absolute errors and a mismatch flag.
// Depends on idestat_pkg.
`timescale 1ns / 1ps

module idestat_front import idestat_pkg::*; (
  input  pixel_t pixel,
  output cls_t   cls
);

  always_comb begin
    cls.err[CH_RED]   = abs_diff(pixel.own_red,   pixel.ref_red);
    cls.err[CH_GREEN] = abs_diff(pixel.own_green, pixel.ref_green);
    cls.err[CH_BLUE]  = abs_diff(pixel.own_blue,  pixel.ref_blue);
    cls.err[CH_ALPHA] = abs_diff(pixel.own_alpha, pixel.ref_alpha);
    cls.differs       = |cls.err;
    cls.last          = pixel.last_pixel;
  end

endmodule

### rtl/idestat_queue.sv
// Two-entry queue of classified pixel pairs between the front and back stages.
// Depends on idestat_pkg.
`timescale 1ns / 1ps

module idestat_queue import idestat_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cls_t wr_data,
  output logic full,
  input  logic rd_en,
  output cls_t rd_data,
  output logic valid
);

  cls_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] cnt;
  logic              do_wr;
  logic              do_rd;

  assign full    = (cnt == QCNT_W'(QUEUE_DEPTH));
  assign valid   = (cnt != '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({do_wr, do_rd})
        2'b10:   cnt <= cnt + QCNT_W'(1);
        2'b01:   cnt <= cnt - QCNT_W'(1);
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

### rtl/idestat_back.sv
// Back stage: saturating accumulators and the result register.
// Depends on idestat_pkg and image_diff_error_statistics_core_macros.svh.
`timescale 1ns / 1ps
`include "image_diff_error_statistics_core_macros.svh"

module idestat_back import idestat_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cls_t  head,
  input  logic  head_valid,
  output logic  take,
  output stat_t stat,
  output logic  out_valid,
  input  logic  pop
);

  logic [COUNT_W-1:0]           mismatch_acc;
  logic [NUM_CH-1:0][SUM_W-1:0] sum_acc;
  logic [NUM_CH-1:0][CH_W-1:0]  peak_acc;

  logic [COUNT_W-1:0]           mismatch_next;
  logic [NUM_CH-1:0][SUM_W-1:0] sum_next;
  logic [NUM_CH-1:0][CH_W-1:0]  peak_next;
  logic [NUM_CH-1:0][SUM_W:0]   sum_ext;
  logic                         finish;

  assign take   = head_valid && (!head.last || !out_valid || pop);
  assign finish = take && head.last;

  always_comb begin
    if (head.differs && (mismatch_acc < COUNT_CAP)) begin
      mismatch_next = mismatch_acc + COUNT_W'(1);
    end else begin
      mismatch_next = mismatch_acc;
    end
    for (int c = 0; c < NUM_CH; c++) begin
      sum_ext[c]   = {1'b0, sum_acc[c]} + (SUM_W+1)'(head.err[c]);
      sum_next[c]  = sum_ext[c][SUM_W] ? {SUM_W{1'b1}} : sum_ext[c][SUM_W-1:0];
      peak_next[c] = max8(head.err[c], peak_acc[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mismatch_acc <= '0;
      sum_acc      <= '0;
      peak_acc     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (finish) begin
        mismatch_acc <= '0;
        sum_acc      <= '0;
        peak_acc     <= '0;
        out_valid    <= 1'b1;
      end else begin
        if (take) begin
          mismatch_acc <= mismatch_next;
          sum_acc      <= sum_next;
          peak_acc     <= peak_next;
        end
        if (pop) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      stat.count <= mismatch_next;
      stat.sums  <= sum_next;
      stat.peaks <= peak_next;
    end
  end

  `IDS_ASSERT_IMP(a_count_cap, 1'b1, mismatch_acc <= COUNT_CAP, "mismatch count above cap")
  `IDS_ASSERT_IMP(a_clean_when_no_mismatch, mismatch_acc == '0,
    (sum_acc == '0) && (peak_acc == '0), "error accumulated without a mismatch")
  `IDS_ASSERT_NXT(a_finish_clears, finish,
    out_valid && (mismatch_acc == '0) && (sum_acc == '0), "last pair did not close the image")

endmodule

### rtl/image_diff_error_statistics_core.sv
// Image difference statistics core: one RGBA8888 pixel pair per clock in while
// full is low, one statistics transaction out per image.
// Depends on idestat_pkg and the front, queue and back modules.
// A pixel pair pushed while full is low is accepted every clock cycle, and its
// per-channel absolute errors are computed in the same cycle and written into a
// two-entry queue. The back stage drains that queue at one pair per cycle, save
// while a last pair is held, with a saturating add and compare per channel. The
// transaction for an image is registered when the back stage takes its last pair,
// and stays until popped. A later last pair waits at the head of the queue only
// while that transaction is still unread; the pairs behind it wait too, and full
// rises once the queue holds two. No clearing pass is needed after reset.
`timescale 1ns / 1ps

module image_diff_error_statistics_core import idestat_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  pixel_t  pixel,
  input  logic    pop,
  output logic    empty,
  output result_t result
);

  cls_t  front_cls;
  cls_t  head;
  logic  head_valid;
  logic  take;
  stat_t stat;
  logic  out_valid;

  idestat_front u_front (
    .pixel (pixel),
    .cls   (front_cls)
  );

  idestat_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (front_cls),
    .full    (full),
    .rd_en   (take),
    .rd_data (head),
    .valid   (head_valid)
  );

  idestat_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .take       (take),
    .stat       (stat),
    .out_valid  (out_valid),
    .pop        (pop)
  );

  assign empty = !out_valid;

  always_comb begin
    result.images_identical = (stat.count == '0);
    result.mismatch_count   = stat.count;
    result.sum_red          = stat.sums[CH_RED];
    result.sum_green        = stat.sums[CH_GREEN];
    result.sum_blue         = stat.sums[CH_BLUE];
    result.sum_alpha        = stat.sums[CH_ALPHA];
    result.sum_all          = TOTAL_W'(stat.sums[CH_RED]) + TOTAL_W'(stat.sums[CH_GREEN])
                            + TOTAL_W'(stat.sums[CH_BLUE]) + TOTAL_W'(stat.sums[CH_ALPHA]);
    result.peak_red         = stat.peaks[CH_RED];
    result.peak_green       = stat.peaks[CH_GREEN];
    result.peak_blue        = stat.peaks[CH_BLUE];
    result.peak_alpha       = stat.peaks[CH_ALPHA];
    result.peak_all         = max8(max8(stat.peaks[CH_RED], stat.peaks[CH_GREEN]),
                                   max8(stat.peaks[CH_BLUE], stat.peaks[CH_ALPHA]));
  end

endmodule

### tb/sv/tb.sv
// Testbench for image_diff_error_statistics_core: directed pixel pairs, then random images.
// Statistics transactions are checked against an in-bench accumulator model.
// Depends on idestat_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
  import idestat_pkg::*;

  typedef struct {
    pixel_t  px;
    bit      typed;
    result_t want;
  } plan_row_t;

  logic    clk;
  logic    rst;
  logic    push;
  logic    full;
  pixel_t  pixel;
  logic    pop;
  logic    empty;
  result_t result;

  int      error_count;
  int      items_sent;
  bit      steady;
  int      pop_left;
  result_t stats_q[$];
  result_t stats_head;

  logic [COUNT_W-1:0] diff_pixels;
  logic [SUM_W-1:0]   err_total[NUM_CH];
  logic [CH_W-1:0]    err_peak[NUM_CH];

  image_diff_error_statistics_core DUT (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .pixel  (pixel),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit fold_pixel(input pixel_t p, output result_t r);
    logic [CH_W-1:0]    a[NUM_CH];
    logic [CH_W-1:0]    b[NUM_CH];
    logic [CH_W-1:0]    e[NUM_CH];
    logic [SUM_W:0]     s;
    logic [TOTAL_W-1:0] all;
    logic [CH_W-1:0]    top;
    bit                 differs;
    a = '{p.own_red, p.own_green, p.own_blue, p.own_alpha};
    b = '{p.ref_red, p.ref_green, p.ref_blue, p.ref_alpha};
    differs = 1'b0;
    r = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      e[c] = (a[c] >= b[c]) ? a[c] - b[c] : b[c] - a[c];
      if (e[c] != '0) differs = 1'b1;
    end
    if (differs) begin
      if (diff_pixels < COUNT_CAP) diff_pixels = diff_pixels + COUNT_W'(1);
      for (int c = 0; c < NUM_CH; c++) begin
        s = {1'b0, err_total[c]} + (SUM_W+1)'(e[c]);
        err_total[c] = s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
        if (e[c] > err_peak[c]) err_peak[c] = e[c];
      end
    end
    if (!p.last_pixel) return 1'b0;
    all = '0;
    top = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      all = all + TOTAL_W'(err_total[c]);
      if (err_peak[c] > top) top = err_peak[c];
    end
    r.images_identical = (diff_pixels == '0);
    r.mismatch_count   = diff_pixels;
    r.sum_red          = err_total[CH_RED];
    r.sum_green        = err_total[CH_GREEN];
    r.sum_blue         = err_total[CH_BLUE];
    r.sum_alpha        = err_total[CH_ALPHA];
    r.sum_all          = all;
    r.peak_red         = err_peak[CH_RED];
    r.peak_green       = err_peak[CH_GREEN];
    r.peak_blue        = err_peak[CH_BLUE];
    r.peak_alpha       = err_peak[CH_ALPHA];
    r.peak_all         = top;
    diff_pixels = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      err_total[c] = '0;
      err_peak[c]  = '0;
    end
    return 1'b1;
  endfunction

  function automatic pixel_t pix(input logic [31:0] own, input logic [31:0] theirs,
                                 input bit last);
    return {own, theirs, last};
  endfunction

  function automatic pixel_t random_pixel(input bit last);
    pixel_t p;
    int     kind;
    p = {$urandom, $urandom, 1'b0};
    kind = $urandom_range(0, 9);
    if (kind <= 4) begin
      p.ref_red   = p.own_red;
      p.ref_green = p.own_green;
      p.ref_blue  = p.own_blue;
      p.ref_alpha = p.own_alpha;
      if (kind >= 3) begin
        case ($urandom_range(0, 3))
          CH_RED:   p.ref_red   = CH_W'($urandom);
          CH_GREEN: p.ref_green = CH_W'($urandom);
          CH_BLUE:  p.ref_blue  = CH_W'($urandom);
          default:  p.ref_alpha = CH_W'($urandom);
        endcase
      end
    end else if (kind == 5) begin
      p.own_red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.own_green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.own_blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.own_alpha = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.ref_red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.ref_green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.ref_blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.ref_alpha = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    p.last_pixel = last;
    return p;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input longint unsigned got,
                             input longint unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  task automatic check_stats(input result_t got, input result_t want);
    check_field("images_identical", 64'(got.images_identical), 64'(want.images_identical));
    check_field("mismatch_count", 64'(got.mismatch_count), 64'(want.mismatch_count));
    check_field("sum_red", 64'(got.sum_red), 64'(want.sum_red));
    check_field("sum_green", 64'(got.sum_green), 64'(want.sum_green));
    check_field("sum_blue", 64'(got.sum_blue), 64'(want.sum_blue));
    check_field("sum_alpha", 64'(got.sum_alpha), 64'(want.sum_alpha));
    check_field("sum_all", 64'(got.sum_all), 64'(want.sum_all));
    check_field("peak_red", 64'(got.peak_red), 64'(want.peak_red));
    check_field("peak_green", 64'(got.peak_green), 64'(want.peak_green));
    check_field("peak_blue", 64'(got.peak_blue), 64'(want.peak_blue));
    check_field("peak_alpha", 64'(got.peak_alpha), 64'(want.peak_alpha));
    check_field("peak_all", 64'(got.peak_all), 64'(want.peak_all));
  endtask

  task automatic idle_push(input int cycles);
    push <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic send_pixel(input pixel_t p, input bit typed, input result_t want);
    bit      accepted;
    result_t r;
    push  <= 1'b1;
    pixel <= p;
    forever begin
      @(posedge clk);
      accepted = !full;
      if (accepted && fold_pixel(p, r)) stats_q.push_back(typed ? want : r);
      @(negedge clk);
      if (accepted) break;
    end
    items_sent++;
  endtask

  always @(negedge clk) begin
    if (rst) begin
      pop      <= 1'b0;
      pop_left <= 0;
    end else if (pop_left > 0) begin
      pop_left <= pop_left - 1;
    end else if (steady || $urandom_range(0, 2) != 0) begin
      pop      <= 1'b1;
      pop_left <= $urandom_range(0, 19);
    end else begin
      pop      <= 1'b0;
      pop_left <= $urandom_range(0, 10);
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (stats_q.size() == 0) begin
        report_mismatch("statistics transaction with none expected");
      end else begin
        stats_head = stats_q.pop_front();
        check_stats(result, stats_head);
      end
    end
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    plan_row_t plan[$];
    result_t   none;
    result_t   same;
    result_t   full_swing;
    int        len;
    bit        drained;
    clk         = 1'b0;
    rst         = 1'b1;
    push        = 1'b0;
    pixel       = '0;
    pop         = 1'b0;
    error_count = 0;
    items_sent  = 0;
    steady      = 1'b0;
    pop_left    = 0;
    drained     = 1'b0;
    diff_pixels = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      err_total[c] = '0;
      err_peak[c]  = '0;
    end
    none = '0;
    same = '{images_identical: 1'b1, default: '0};
    full_swing = '{1'b1 ^ 1'b1, 25'd1, 32'd255, 32'd255, 32'd255, 32'd255, 34'd1020,
                   8'd255, 8'd255, 8'd255, 8'd255, 8'd255};

    plan.push_back('{pix(32'h00000000, 32'h00000000, 1'b1), 1'b1, same});
    plan.push_back('{pix(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1), 1'b1, same});
    plan.push_back('{pix(32'hFFFFFFFF, 32'h00000000, 1'b1), 1'b1, full_swing});
    plan.push_back('{pix(32'h00000000, 32'hFFFFFFFF, 1'b1), 1'b1, full_swing});
    plan.push_back('{pix(32'h01000000, 32'h00000000, 1'b1), 1'b1,
                     '{1'b0, 25'd1, 32'd1, 32'd0, 32'd0, 32'd0, 34'd1,
                       8'd1, 8'd0, 8'd0, 8'd0, 8'd1}});
    plan.push_back('{pix(32'h12345600, 32'h123456C8, 1'b1), 1'b1,
                     '{1'b0, 25'd1, 32'd0, 32'd0, 32'd0, 32'd200, 34'd200,
                       8'd0, 8'd0, 8'd0, 8'd200, 8'd200}});
    plan.push_back('{pix(32'h0A141E28, 32'h281E140A, 1'b0), 1'b0, none});
    plan.push_back('{pix(32'h55555555, 32'h55555555, 1'b0), 1'b0, none});
    plan.push_back('{pix(32'hAAAAAAAA, 32'h55555555, 1'b0), 1'b0, none});
    plan.push_back('{pix(32'h01010101, 32'h00000000, 1'b0), 1'b0, none});
    plan.push_back('{pix(32'h80808080, 32'h80808080, 1'b1), 1'b0, none});
    plan.push_back('{pix(32'h7F7F7F7F, 32'h7F7F7F7F, 1'b0), 1'b0, none});
    plan.push_back('{pix(32'hC3C3C3C3, 32'hC3C3C3C3, 1'b0), 1'b0, none});
    plan.push_back('{pix(32'h3C3C3C3C, 32'h3C3C3C3C, 1'b1), 1'b1, same});
    plan.push_back('{pix(32'h00FF0000, 32'h00000000, 1'b0), 1'b0, none});
    plan.push_back('{pix(32'h00008000, 32'h00000000, 1'b0), 1'b0, none});
    plan.push_back('{pix(32'h00000001, 32'h000000FF, 1'b1), 1'b0, none});

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if ($urandom_range(0, 3) == 0) idle_push($urandom_range(1, 11));
      send_pixel(plan[i].px, plan[i].typed, plan[i].want);
    end

    while (items_sent < 600) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 60) : $urandom_range(1, 8);
      if (!drained && items_sent >= 300) begin
        push <= 1'b0;
        wait (stats_q.size() == 0);
        @(negedge clk);
        drained = 1'b1;
      end
      steady = (items_sent >= 520);
      for (int k = 0; k < len; k++) begin
        if (!steady && $urandom_range(0, 4) == 0) idle_push($urandom_range(1, 11));
        send_pixel(random_pixel(k == len - 1), 1'b0, none);
      end
    end
    push <= 1'b0;

    wait (stats_q.size() == 0);
    repeat (10) @(posedge clk);
    if (error_count == 0 && stats_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
